[hdl/gha_pkg.sv]
package gha_pkg;

  // Default geometry of the handle table
  localparam int unsigned COLUMN_BITS_DEF = 4;
  localparam int unsigned ROW_BITS_DEF    = 4;
  localparam int unsigned GEN_BITS_DEF    = 8;

  // Fixed port widths
  localparam int unsigned FUNC_W   = 2;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned HANDLE_W = 16;

  // Operation codes
  localparam logic [FUNC_W-1:0] FUNC_ALLOC  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_LOOKUP = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_FREE   = 2'd2;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_STALE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

endpackage

[hdl/gha_ffz.sv]
module gha_ffz #(
  parameter int unsigned W = 16
) (
  input  logic [W-1:0]         vec,
  output logic                 found,
  output logic [$clog2(W)-1:0] idx
);

  localparam int unsigned IW = $clog2(W);

  // Find the lowest clear bit; scanning downward lets the lowest one win
  always_comb begin
    found = 1'b0;
    idx   = '0;
    for (int i = W - 1; i >= 0; i--) begin
      if (!vec[i]) begin
        found = 1'b1;
        idx   = IW'(i);
      end
    end
  end

endmodule

[hdl/generational_handle_allocator.sv]
// Channel   Ports                                   Handshake
// request   in_func, in_handle                      start high while busy low
// result    out_status, out_result_handle           out_valid strobe, one cycle
//
// Allocate runs a row search, then a column search unless the table is full;
// look up and free run a check; an unused operation code is answered from
// idle. Allocate finds the lowest row with a free slot (row-full vector), then
// the free column in the row read from the occupancy memory, both through one
// shared find-first-zero unit. Look up and free read both memories at accept
// and check on the next cycle. Reset is synchronous; row valid bits make every
// entry read as free right after reset, so no clearing pass is needed. The
// receiver cannot stall: a result is shown for one cycle and busy drops as it
// appears, so the next request can be taken in that same cycle.
module generational_handle_allocator #(
  parameter int unsigned COLUMN_BITS = gha_pkg::COLUMN_BITS_DEF,
  parameter int unsigned ROW_BITS    = gha_pkg::ROW_BITS_DEF,
  parameter int unsigned GEN_BITS    = gha_pkg::GEN_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [gha_pkg::FUNC_W-1:0]    in_func,
  input  logic [gha_pkg::HANDLE_W-1:0]  in_handle,
  output logic                          out_valid,
  output logic [gha_pkg::STATUS_W-1:0]  out_status,
  output logic [gha_pkg::HANDLE_W-1:0]  out_result_handle
);

  localparam int unsigned INDEX_BITS = COLUMN_BITS + ROW_BITS;
  localparam int unsigned ROWS       = 1 << ROW_BITS;
  localparam int unsigned COLS       = 1 << COLUMN_BITS;
  localparam int unsigned ENTRIES    = 1 << INDEX_BITS;
  localparam int unsigned FW         = (ROWS > COLS) ? ROWS : COLS;
  localparam int unsigned FIW        = $clog2(FW);
  localparam int unsigned HW         = gha_pkg::HANDLE_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_AROW = 2'd1;
  localparam logic [1:0] S_ACOL = 2'd2;
  localparam logic [1:0] S_CHK  = 2'd3;

  logic [1:0]             state_r, state_nxt;
  logic [GEN_BITS-1:0]    gen_cnt_r;
  logic [HW-1:0]          handle_r;
  logic                   is_free_r;
  logic [ROW_BITS-1:0]    row_r;
  logic [ROWS-1:0]        row_full_r;
  logic [ROWS-1:0]        row_valid_r;

  // Occupancy rows and stored generations
  logic [COLS-1:0]        occ_mem [ROWS];
  logic [GEN_BITS-1:0]    gen_mem [ENTRIES];
  logic [COLS-1:0]        occ_rd_r;
  logic [GEN_BITS-1:0]    gen_rd_r;
  logic [ROW_BITS-1:0]    occ_rd_addr;

  logic                   out_valid_r;
  logic [gha_pkg::STATUS_W-1:0] out_status_r;
  logic [HW-1:0]          out_handle_r;

  // Request handle fields
  logic [INDEX_BITS-1:0]  in_idx;
  logic [INDEX_BITS-1:0]  h_idx;
  logic [HW-1:0]          h_shift;
  logic [GEN_BITS-1:0]    h_gen;
  logic [ROW_BITS-1:0]    h_row;
  logic [COLUMN_BITS-1:0] h_col;

  // Shared search unit
  logic [FW-1:0]          ffz_vec;
  logic                   ffz_found;
  logic [FIW-1:0]         ffz_idx;

  logic [COLS-1:0]        row_data;
  logic [COLUMN_BITS-1:0] alloc_col;
  logic [COLS-1:0]        alloc_row_new;
  logic [GEN_BITS-1:0]    gen_inc;
  logic [GEN_BITS-1:0]    gen_new;
  logic [31:0]            alloc_handle;
  logic [COLS-1:0]        chk_bit;
  logic                   chk_busy;
  logic                   chk_match;
  logic                   accept;

  assign accept = start && (state_r == S_IDLE);
  assign busy   = (state_r != S_IDLE);

  assign in_idx   = in_handle[INDEX_BITS-1:0];
  assign h_idx    = handle_r[INDEX_BITS-1:0];
  assign h_shift  = handle_r >> INDEX_BITS;
  assign h_gen    = h_shift[GEN_BITS-1:0];
  assign h_row    = h_idx[INDEX_BITS-1:COLUMN_BITS];
  assign h_col    = h_idx[COLUMN_BITS-1:0];

  // A row never written reads as all free
  always_comb begin
    if (state_r == S_ACOL) begin
      row_data = row_valid_r[row_r] ? occ_rd_r : '0;
    end else begin
      row_data = row_valid_r[h_row] ? occ_rd_r : '0;
    end
  end

  // Feed the search unit with row-full flags or the occupancy of one row
  always_comb begin
    ffz_vec = '1;
    if (state_r == S_AROW) begin
      ffz_vec[ROWS-1:0] = row_full_r;
    end else begin
      ffz_vec[COLS-1:0] = row_data;
    end
  end

  gha_ffz #(
    .W (FW)
  ) u_ffz (
    .vec   (ffz_vec),
    .found (ffz_found),
    .idx   (ffz_idx)
  );

  // Allocation: next generation skips zero
  assign alloc_col     = ffz_idx[COLUMN_BITS-1:0];
  assign alloc_row_new = row_data | (COLS'(1) << alloc_col);
  assign gen_inc       = gen_cnt_r + GEN_BITS'(1);
  assign gen_new       = (gen_inc == '0) ? GEN_BITS'(1) : gen_inc;
  assign alloc_handle  = 32'({gen_new, row_r, alloc_col});

  // Check: the entry must be occupied and hold the handle's generation; generation zero never matches
  assign chk_bit   = COLS'(1) << h_col;
  assign chk_busy  = |(row_data & chk_bit);
  assign chk_match = (h_gen != '0) && chk_busy && (gen_rd_r == h_gen);

  // Read address of the occupancy memory
  always_comb begin
    if (state_r == S_AROW) begin
      occ_rd_addr = ffz_idx[ROW_BITS-1:0];
    end else begin
      occ_rd_addr = in_idx[INDEX_BITS-1:COLUMN_BITS];
    end
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          priority if (in_func == gha_pkg::FUNC_ALLOC) begin
            state_nxt = S_AROW;
          end else if (in_func == gha_pkg::FUNC_LOOKUP ||
                       in_func == gha_pkg::FUNC_FREE) begin
            state_nxt = S_CHK;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_AROW: state_nxt = ffz_found ? S_ACOL : S_IDLE;
      S_ACOL: state_nxt = S_IDLE;
      S_CHK:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      gen_cnt_r   <= '0;
      row_full_r  <= '0;
      row_valid_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (accept && in_func != gha_pkg::FUNC_ALLOC &&
              in_func != gha_pkg::FUNC_LOOKUP && in_func != gha_pkg::FUNC_FREE) begin
            out_valid_r <= 1'b1;
          end
        end
        S_AROW: begin
          if (!ffz_found) begin
            out_valid_r <= 1'b1;
          end
        end
        S_ACOL: begin
          gen_cnt_r          <= gen_new;
          row_valid_r[row_r] <= 1'b1;
          row_full_r[row_r]  <= &alloc_row_new;
          out_valid_r        <= 1'b1;
        end
        S_CHK: begin
          if (chk_match && is_free_r) begin
            row_valid_r[h_row] <= 1'b1;
            row_full_r[h_row]  <= 1'b0;
          end
          out_valid_r <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      handle_r  <= in_handle;
      is_free_r <= (in_func == gha_pkg::FUNC_FREE);
    end
    if (state_r == S_AROW) begin
      row_r <= ffz_idx[ROW_BITS-1:0];
    end
    unique case (state_r)
      S_IDLE: begin
        out_status_r <= gha_pkg::ST_STALE;
        out_handle_r <= '0;
      end
      S_AROW: begin
        out_status_r <= gha_pkg::ST_FULL;
        out_handle_r <= '0;
      end
      S_ACOL: begin
        out_status_r <= gha_pkg::ST_OK;
        out_handle_r <= alloc_handle[HW-1:0];
      end
      S_CHK: begin
        out_status_r <= chk_match ? gha_pkg::ST_OK : gha_pkg::ST_STALE;
        out_handle_r <= chk_match ? handle_r : '0;
      end
      default: ;
    endcase
  end

  // Memories: registered reads, one write each
  always_ff @(posedge clk) begin
    occ_rd_r <= occ_mem[occ_rd_addr];
    gen_rd_r <= gen_mem[in_idx];
    if (state_r == S_ACOL) begin
      occ_mem[row_r]            <= alloc_row_new;
      gen_mem[{row_r, alloc_col}] <= gen_new;
    end else if (state_r == S_CHK && chk_match && is_free_r) begin
      occ_mem[h_row] <= row_data & ~chk_bit;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_result_handle = out_handle_r;

endmodule
